>>> rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // Timestamp width inside the block and on the scan port.
  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_WIDTH      = 32;

  // Configuration registers.
  localparam int CFG_WIDTH     = 24;
  localparam int CFG_IDX_WIDTH = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_FIELDS_W  = 1 + NOW_WIDTH;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 6;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Reset values of the configuration registers.
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = CFG_WIDTH'(50000);
  localparam logic [CFG_WIDTH-1:0] SHORT_RST    = CFG_WIDTH'(500000);
  localparam logic [CFG_WIDTH-1:0] LONG_RST     = CFG_WIDTH'(1000000);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_SHORT    = 2'd1,
    CFG_LONG     = 2'd2
  } cfg_idx_t;

  // One classified scan result.
  typedef struct packed {
    logic long_event;
    logic short_event;
    logic release_edge;
    logic press_edge;
    logic pressing;
    logic steady_level;
  } result_t;

endpackage

>>> rtl/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces an active-low button from timestamped scans and reports press,
// release, short-press and long-press events, one result per scan.
// ----------------------------------------------------------------------------
// Path: an accepted scan is held in the input register and moves into the result
// register once that is empty or being drained; its result is then on out_tvalid.
// Throughput: one scan per cycle while the output is not stalled; the state update
// is a single subtract and compare pass between the input and result registers.
// Reset: rst_n is synchronous and active low; it empties both registers, sets
// the debounce state to released and loads the default timing registers.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier #(
  parameter int TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Scan channel. tdata: [0] pin_level, [32:1] now_us, rest zero.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bdpc_pkg::IN_TDATA_W-1:0] in_tdata,
  // Result channel. tdata: [0] steady_level, [1] pressing, [2] press_edge,
  // [3] release_edge, [4] short_event, [5] long_event, rest zero.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bdpc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [bdpc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [bdpc_pkg::CFG_WIDTH-1:0]  cfg_data
);
  import bdpc_pkg::*;

  // Compare width covers both the time differences and the 24-bit limits.
  localparam int CMP_W = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  // Configuration registers.
  logic [CFG_WIDTH-1:0] debounce_r, short_r, long_r;

  // Input register.
  logic  in_valid_r;
  logic  in_level_r;
  time_t in_now_r;

  // Debounce and classification state.
  logic  flicker_r, flicker_nxt;
  time_t change_time_r, change_time_nxt;
  logic  prev_steady_r, prev_steady_nxt;
  logic  cur_steady_r, cur_steady_nxt;
  logic  pressing_r, pressing_nxt;
  time_t press_time_r, press_time_nxt;
  logic  long_rep_r, long_rep_nxt;

  // Result register.
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic  advance;
  logic  level_changed;
  time_t el_change, el_press;
  logic  accept_level;
  logic  long_armed;

  // The result register takes a new scan when empty or being drained.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      short_r    <= SHORT_RST;
      long_r     <= LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_r <= cfg_data;
        CFG_SHORT:    short_r    <= cfg_data;
        CFG_LONG:     long_r     <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_level_r <= in_tdata[0];
      in_now_r   <= TIME_WIDTH'(in_tdata[NOW_WIDTH:1]);
    end
  end

  // One scan: debounce, edge detection and press classification.
  always_comb begin
    flicker_nxt     = flicker_r;
    change_time_nxt = change_time_r;
    prev_steady_nxt = prev_steady_r;
    cur_steady_nxt  = cur_steady_r;
    pressing_nxt    = pressing_r;
    press_time_nxt  = press_time_r;
    long_rep_nxt    = long_rep_r;
    res_nxt         = '0;

    // A level change restarts the debounce timer, so its elapsed time is zero.
    level_changed = (in_level_r != flicker_r);
    el_change     = level_changed ? '0 : (in_now_r - change_time_r);
    if (level_changed) begin
      flicker_nxt     = in_level_r;
      change_time_nxt = in_now_r;
    end

    accept_level = (CMP_W'(el_change) >= CMP_W'(debounce_r));
    if (accept_level) begin
      pressing_nxt    = !in_level_r;
      prev_steady_nxt = cur_steady_r;
      cur_steady_nxt  = in_level_r;
    end

    res_nxt.press_edge   = prev_steady_nxt && !cur_steady_nxt;
    res_nxt.release_edge = !prev_steady_nxt && cur_steady_nxt;

    // A press edge restarts the hold time and re-arms the long event.
    el_press = res_nxt.press_edge ? '0 : (in_now_r - press_time_r);
    if (res_nxt.press_edge) begin
      press_time_nxt = in_now_r;
    end
    long_armed = res_nxt.press_edge || !long_rep_r;

    res_nxt.short_event = res_nxt.release_edge &&
                          (CMP_W'(el_press) < CMP_W'(short_r));

    if (pressing_nxt && long_armed && (CMP_W'(el_press) > CMP_W'(long_r))) begin
      res_nxt.long_event = 1'b1;
    end
    long_rep_nxt = res_nxt.long_event || (!res_nxt.press_edge && long_rep_r);

    res_nxt.steady_level = cur_steady_nxt;
    res_nxt.pressing     = pressing_nxt;
  end

  // State update, once per scan that moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flicker_r     <= 1'b1;
      change_time_r <= '0;
      prev_steady_r <= 1'b1;
      cur_steady_r  <= 1'b1;
      pressing_r    <= 1'b0;
      press_time_r  <= '0;
      long_rep_r    <= 1'b0;
    end else if (advance) begin
      flicker_r     <= flicker_nxt;
      change_time_r <= change_time_nxt;
      prev_steady_r <= prev_steady_nxt;
      cur_steady_r  <= cur_steady_nxt;
      pressing_r    <= pressing_nxt;
      press_time_r  <= press_time_nxt;
      long_rep_r    <= long_rep_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(res_r);

  // The stored steady pair can never show both edges at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.press_edge && res_r.release_edge))
    else $error("press and release edge reported together");

  // A short event only comes with a release edge.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.short_event |-> res_r.release_edge)
    else $error("short event without release edge");

  // A long event is only reported while the button is pressed.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.long_event |-> res_r.pressing)
    else $error("long event while released");

  // Once a long event is reported, no second one follows without a new press.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && long_rep_r && !res_nxt.press_edge |-> !res_nxt.long_event)
    else $error("second long event within one press");

endmodule
